// ----- rtl/lsc_pkg.sv -----
package lsc_pkg;

  localparam int RangeW = 20;
  localparam int IndexW = 12;
  localparam int AngleW = 32;
  localparam int CoordW = 24;
  localparam int TrigW = 16;
  localparam int CordicSteps = 24;
  // CORDIC datapath: range (20 bits) times 39797 (16 bits) plus growth and sign.
  localparam int CordW = 40;
  localparam int ZW = 33;
  localparam int SxW = CordW - 12;
  localparam logic [15:0] KinvQ16 = 16'd39797;

  localparam int CfgAddrW = 5;
  localparam logic [2:0] RegStartAngle = 3'd0;
  localparam logic [2:0] RegAngleStep = 3'd1;
  localparam logic [2:0] RegMinRange = 3'd2;
  localparam logic [2:0] RegMaxRange = 3'd3;
  localparam logic [2:0] RegRotCos = 3'd4;
  localparam logic [2:0] RegRotSin = 3'd5;
  localparam logic [2:0] RegOffsetX = 3'd6;
  localparam logic [2:0] RegOffsetY = 3'd7;

  typedef struct packed {
    logic [RangeW-1:0] range_value;
    logic              range_finite;
    logic [IndexW-1:0] beam_index;
    logic              scan_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     point_kept;
    logic                     scan_done;
  } out_item_t;

  function automatic logic [AngleW-1:0] atan_lut(input logic [4:0] i);
    logic [AngleW-1:0] v;
    unique case (i)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lsc_if.sv -----
interface lsc_in_if;
  import lsc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lsc_out_if;
  import lsc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/laser_scan_to_cartesian.sv -----
// Throughput: one transaction per cycle when the output is not stalled; the only loop
// is the 24-step CORDIC, which is unrolled into one register stage per step, so nothing
// is shared between items.
// A stall holds the whole pipeline in place (global enable); nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register defaults.
module laser_scan_to_cartesian #(
  parameter int MAX_BEAMS = 4096,
  parameter int RANGE_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lsc_in_if.sink                        in_ch,
  lsc_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lsc_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import lsc_pkg::*;

  localparam int NStages = CordicSteps + 5;
  localparam logic [RangeW-1:0] RangeMask =
    (RANGE_BITS >= RangeW) ? {RangeW{1'b1}} : RangeW'((64'd1 << RANGE_BITS) - 64'd1);

  // Configuration registers.
  logic signed [AngleW-1:0] start_angle_r, angle_step_r;
  logic [RangeW-1:0]        min_range_r, max_range_r;
  logic signed [TrigW-1:0]  rot_cos_r, rot_sin_r;
  logic signed [CoordW-1:0] offset_x_r, offset_y_r;
  logic                     cfg_wr;
  logic [2:0]               cfg_idx;
  logic                     cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_hit = cfg_paddr[1:0] == 2'b00;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r <= '0;
      min_range_r <= '0;
      max_range_r <= {RangeW{1'b1}};
      rot_cos_r <= 16'sd32767;
      rot_sin_r <= '0;
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegStartAngle: start_angle_r <= cfg_pwdata;
        RegAngleStep: angle_step_r <= cfg_pwdata;
        RegMinRange: min_range_r <= cfg_pwdata[RangeW-1:0];
        RegMaxRange: max_range_r <= cfg_pwdata[RangeW-1:0];
        RegRotCos: rot_cos_r <= cfg_pwdata[TrigW-1:0];
        RegRotSin: rot_sin_r <= cfg_pwdata[TrigW-1:0];
        RegOffsetX: offset_x_r <= cfg_pwdata[CoordW-1:0];
        RegOffsetY: offset_y_r <= cfg_pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_hit) begin
      unique case (cfg_idx)
        RegStartAngle: cfg_prdata = start_angle_r;
        RegAngleStep: cfg_prdata = angle_step_r;
        RegMinRange: cfg_prdata = {12'd0, min_range_r};
        RegMaxRange: cfg_prdata = {12'd0, max_range_r};
        RegRotCos: cfg_prdata = {16'd0, rot_cos_r};
        RegRotSin: cfg_prdata = {16'd0, rot_sin_r};
        RegOffsetX: cfg_prdata = {8'd0, offset_x_r};
        RegOffsetY: cfg_prdata = {8'd0, offset_y_r};
        default: cfg_prdata = '0;
      endcase
    end
  end

  // Pipeline: global enable; the output register plus the valid chain decide.
  logic [NStages-1:0] vld_r;
  logic               adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NStages-2:0], in_ch.valid};
    end
  end

  // Stage 1: filter, angle multiply, range scale.
  logic [RangeW-1:0]       rng;
  logic                    keep_in;
  logic                    kept_r [CordicSteps+4];
  logic                    done_r [CordicSteps+4];
  logic [AngleW-1:0]       prod_r;
  logic [AngleW-1:0]       start_r;
  logic signed [CordW-1:0] xs_r;

  assign rng = in_ch.data.range_value & RangeMask;
  assign keep_in = in_ch.data.range_finite && (rng >= min_range_r) && (rng <= max_range_r)
                   && (32'(in_ch.data.beam_index) < 32'(MAX_BEAMS));

  always_ff @(posedge clk) begin
    if (adv) begin
      kept_r[0] <= keep_in;
      done_r[0] <= in_ch.data.scan_end;
      prod_r <= AngleW'({20'd0, in_ch.data.beam_index} * angle_step_r);
      start_r <= start_angle_r;
      xs_r <= $signed(CordW'(rng) * CordW'(KinvQ16));
    end
  end

  // Stage 2: angle add and quadrant fold.
  logic [AngleW-1:0]       ang;
  logic                    fold;
  logic signed [CordW-1:0] cx_r [CordicSteps+1];
  logic signed [CordW-1:0] cy_r [CordicSteps+1];
  logic signed [ZW-1:0]    cz_r [CordicSteps+1];

  assign ang = prod_r + start_r;
  assign fold = ang[31] ^ ang[30];

  always_ff @(posedge clk) begin
    if (adv) begin
      kept_r[1] <= kept_r[0];
      done_r[1] <= done_r[0];
      cx_r[0] <= fold ? -xs_r : xs_r;
      cy_r[0] <= '0;
      cz_r[0] <= ZW'($signed(fold ? ang + 32'h80000000 : ang));
    end
  end

  // CORDIC, one rotation per stage.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic signed [ZW-1:0] atn;
    assign atn = ZW'(atan_lut(5'(i)));
    always_ff @(posedge clk) begin
      if (adv) begin
        kept_r[i+2] <= kept_r[i+1];
        done_r[i+2] <= done_r[i+1];
        if (!cz_r[i][ZW-1]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - atn;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + atn;
        end
      end
    end
  end

  // Products of the yaw rotation.
  localparam int PW = SxW + 18;
  logic signed [SxW-1:0] sx, sy;
  logic signed [17:0]    cc, ss;
  logic signed [PW-1:0]  p_cx_r, p_sy_r, p_sx_r, p_cy_r;

  assign sx = cx_r[CordicSteps][CordW-1:12];
  assign sy = cy_r[CordicSteps][CordW-1:12];
  // The default yaw pair is treated as exact identity.
  assign cc = (rot_cos_r == 16'sd32767 && rot_sin_r == 16'sd0) ? 18'sd32768 : 18'(rot_cos_r);
  assign ss = 18'(rot_sin_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      kept_r[CordicSteps+2] <= kept_r[CordicSteps+1];
      done_r[CordicSteps+2] <= done_r[CordicSteps+1];
      p_cx_r <= PW'(cc) * PW'(sx);
      p_sy_r <= PW'(ss) * PW'(sy);
      p_sx_r <= PW'(ss) * PW'(sx);
      p_cy_r <= PW'(cc) * PW'(sy);
    end
  end

  // Sum, round, offset.
  localparam int SW = PW + 1;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [SW-1:0] px_r, py_r;

  assign sum_x = SW'(p_cx_r) - SW'(p_sy_r) + SW'(262144);
  assign sum_y = SW'(p_sx_r) + SW'(p_cy_r) + SW'(262144);

  always_ff @(posedge clk) begin
    if (adv) begin
      kept_r[CordicSteps+3] <= kept_r[CordicSteps+2];
      done_r[CordicSteps+3] <= done_r[CordicSteps+2];
      px_r <= (sum_x >>> 19) + SW'(offset_x_r);
      py_r <= (sum_y >>> 19) + SW'(offset_y_r);
    end
  end

  // Saturate into the output register.
  function automatic logic signed [CoordW-1:0] sat24(input logic signed [SW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SW'(8388607)) r = 24'sh7FFFFF;
    else if (v < -SW'(8388608)) r = 24'sh800000;
    else r = v[CoordW-1:0];
    return r;
  endfunction

  out_item_t res_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.point_kept <= kept_r[CordicSteps+3];
      res_r.scan_done <= done_r[CordicSteps+3];
      res_r.point_x <= kept_r[CordicSteps+3] ? sat24(px_r) : '0;
      res_r.point_y <= kept_r[CordicSteps+3] ? sat24(py_r) : '0;
    end
  end

  assign out_ch.valid = vld_r[CordicSteps+4];
  assign out_ch.data = res_r;

endmodule

// ----- rtl/lsc_checker.sv -----
module lsc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kept,
  input logic signed [23:0] out_x,
  input logic signed [23:0] out_y,
  input logic cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("result changed while stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kept |-> out_x == 24'sd0 && out_y == 24'sd0)
    else $error("dropped point carries nonzero coordinates");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind laser_scan_to_cartesian lsc_checker u_lsc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_kept(out_ch.data.point_kept),
  .out_x(out_ch.data.point_x),
  .out_y(out_ch.data.point_y),
  .cfg_pready(cfg_pready)
);

// ----- sim/lsc_checker.sv -----
module lsc_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  lsc_in_if           in_ch,
  lsc_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [lsc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          points_pending
);
  import lsc_pkg::*;

  logic [31:0] start_ang, ang_step;
  logic [19:0] rng_lo, rng_hi;
  logic signed [15:0] yaw_cos, yaw_sin;
  logic signed [23:0] off_x, off_y;
  out_item_t points_q[$];

  assign points_pending = points_q.size();

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic out_item_t project_sample(input in_item_t s);
    out_item_t r;
    logic [31:0] ang;
    longint x, y, z, dx, dy, sx, sy, c, sn;
    r = '0;
    r.scan_done = s.scan_end;
    if (!s.range_finite || s.range_value < rng_lo || s.range_value > rng_hi) return r;
    ang = start_ang + 32'(s.beam_index) * ang_step;
    x = longint'(s.range_value) * 39797;
    y = 0;
    if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
      ang = ang + 32'h80000000;
      x = -x;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_lut(5'(i)));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_lut(5'(i)));
      end
    end
    sx = x >>> 12;
    sy = y >>> 12;
    c = yaw_cos;
    sn = yaw_sin;
    if (c == 32767 && sn == 0) c = 32768;
    r.point_x = clamp24(((c * sx - sn * sy + (64'sd1 <<< 18)) >>> 19) + longint'(off_x));
    r.point_y = clamp24(((sn * sx + c * sy + (64'sd1 <<< 18)) >>> 19) + longint'(off_y));
    r.point_kept = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst_n) begin
      start_ang <= '0;
      ang_step <= '0;
      rng_lo <= '0;
      rng_hi <= 20'hFFFFF;
      yaw_cos <= 16'sd32767;
      yaw_sin <= '0;
      off_x <= '0;
      off_y <= '0;
      points_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        points_q.insert(points_q.size(), project_sample(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (points_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = points_q.pop_front();
          if (got.point_x !== want.point_x) report_mismatch("point_x", got.point_x, want.point_x);
          if (got.point_y !== want.point_y) report_mismatch("point_y", got.point_y, want.point_y);
          if (got.point_kept !== want.point_kept)
            report_mismatch("point_kept", got.point_kept, want.point_kept);
          if (got.scan_done !== want.scan_done)
            report_mismatch("scan_done", got.scan_done, want.scan_done);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          RegStartAngle: start_ang <= cfg_pwdata;
          RegAngleStep:  ang_step <= cfg_pwdata;
          RegMinRange:   rng_lo <= cfg_pwdata[19:0];
          RegMaxRange:   rng_hi <= cfg_pwdata[19:0];
          RegRotCos:     yaw_cos <= cfg_pwdata[15:0];
          RegRotSin:     yaw_sin <= cfg_pwdata[15:0];
          RegOffsetX:    off_x <= cfg_pwdata[23:0];
          RegOffsetY:    off_y <= cfg_pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/tb_laser_scan_to_cartesian.sv -----
module tb_laser_scan_to_cartesian;
  import lsc_pkg::*;

  localparam int Latency = 28;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, points_pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycle_count = 0;

  lsc_in_if in_ch();
  lsc_out_if out_ch();

  laser_scan_to_cartesian u_top (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  lsc_scoreboard u_checker (
    .clk, .rst_n, .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .points_pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high after an accepted transaction until the next one or a drain.
  task automatic send_sample(input in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic in_item_t random_sample();
    in_item_t s;
    s.range_value = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(40000));
    s.range_finite = ($urandom_range(9) != 0);
    s.beam_index = 12'($urandom);
    s.scan_end = ($urandom_range(15) == 0);
    return s;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (points_pending != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] sa, input logic [31:0] st, input logic [19:0] lo,
                           input logic [19:0] hi, input logic [15:0] c, input logic [15:0] s,
                           input logic [23:0] ox, input logic [23:0] oy);
    write_reg(RegStartAngle, sa);
    write_reg(RegAngleStep, st);
    write_reg(RegMinRange, {12'd0, lo});
    write_reg(RegMaxRange, {12'd0, hi});
    write_reg(RegRotCos, {{16{c[15]}}, c});
    write_reg(RegRotSin, {{16{s[15]}}, s});
    write_reg(RegOffsetX, {{8{ox[23]}}, ox});
    write_reg(RegOffsetY, {{8{oy[23]}}, oy});
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_sample(random_sample());
    drain();
  endtask

  initial begin
    in_item_t s;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset (identity) transform.
    write_reg(RegAngleStep, 32'h0040_0000);
    s = '0; s.range_finite = 1'b1;
    send_sample(s);
    s.range_value = 20'hFFFFF; s.beam_index = 12'hFFF; s.scan_end = 1'b1;
    send_sample(s);
    s.range_finite = 1'b0; send_sample(s);
    for (int q = 0; q < 8; q++) begin
      s = '0; s.range_finite = 1'b1; s.range_value = 20'd40960;
      s.beam_index = 12'(q * 128); s.scan_end = (q == 7);
      send_sample(s);
    end
    drain();
    // Window edges, a yawed frame and saturating offsets.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 20'd1000, 20'd2000, 16'h8000, 16'h7FFF,
              24'h7FFFFF, 24'h800000);
    for (int b = 0; b < RangeW; b++) begin
      s = '0; s.range_finite = 1'b1; s.range_value = 20'd1 << b; s.beam_index = 12'(b);
      send_sample(s);
    end
    s.range_value = 20'd999; send_sample(s);
    s.range_value = 20'd1000; send_sample(s);
    s.range_value = 20'd2000; send_sample(s);
    s.range_value = 20'd2001; send_sample(s);
    drain();
    // An inverted window drops everything.
    write_reg(RegMinRange, 32'd5000);
    write_reg(RegMaxRange, 32'd10);
    random_phase(20, 0, 0);

    configure(32'h0, 32'h0010_0000, 20'd0, 20'hFFFFF, 16'h7FFF, 16'h0000, 24'h0, 24'h0);
    random_phase(90, 0, 0);
    configure($urandom, $urandom, 20'd100, 20'd300000, 16'h5A82, 16'hA57E,
              24'h001000, 24'hFFF000);
    random_phase(90, 62, 0);
    configure($urandom, $urandom, 20'd0, 20'hFFFFF, 16'h8000, 16'h8000, 24'h7FF000, 24'h800800);
    random_phase(90, 0, 62);
    configure($urandom, $urandom, 20'($urandom_range(500)), 20'hFFFFF, 16'($urandom),
              16'($urandom), 24'($urandom), 24'($urandom));
    random_phase(90, 33, 33);

    // Long receiver hold-off while samples keep coming, so the pipeline backs up.
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(100, 0, 0);
    join

    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
